[design/cesu8_stream_decoder_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the CESU-8 stream decoder
// Shared forms for the concurrent checks of the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef CESU8_STREAM_DECODER_CORE_MACROS_SVH
`define CESU8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/cesu8_sd_pkg.sv]
// ---------------------------------------------------------------------------
// CESU-8 stream decoder package
// Item types, automaton states and constants shared by the decoder RTL.
// ---------------------------------------------------------------------------
`default_nettype none

package cesu8_sd_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_CHAR      = 2'd0;
   localparam logic [1:0] STATUS_INVALID   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   // Data masks and the supplementary plane offset
   localparam logic [7:0]  LEAD3_MASK     = 8'h0F;
   localparam logic [7:0]  LEAD2_MASK     = 8'h1F;
   localparam logic [20:0] SURROGATE_BASE = 21'h10000;

   // Sequence lengths used for the truncation count
   localparam logic [2:0] LEN_TWO    = 3'd2;
   localparam logic [2:0] LEN_THREE  = 3'd3;
   localparam logic [2:0] LEN_PAIR   = 3'd6;
   localparam logic [2:0] TAKEN_ONE  = 3'd1;
   localparam logic [2:0] TAKEN_FIVE = 3'd5;
   localparam logic [2:0] TAKEN_SIX  = 3'd6;

   // Validation automaton
   typedef enum logic [2:0] {
      ST_START      = 3'd0,  // expecting a lead byte
      ST_LAST_TRAIL = 3'd1,  // one trail byte completes the unit
      ST_E0_SECOND  = 3'd2,  // after E0, needs A0-BF
      ST_MID_SECOND = 3'd3,  // after E1-EC/EE-EF, needs any trail
      ST_ED_SECOND  = 3'd4,  // after ED, BMP or high surrogate
      ST_HI_TRAIL   = 3'd5,  // last trail of the high surrogate
      ST_LOW_ED     = 3'd6,  // expecting ED of the low surrogate
      ST_LOW_SECOND = 3'd7   // expecting B0-BF of the low surrogate
   } automaton_state_type;

   typedef struct packed {
      automaton_state_type automaton_state;
      logic [2:0]          bytes_taken;
      logic [7:0]          first_byte;
      logic [15:0]         unit_value;
      logic [9:0]          high_surrogate_bits;
   } dec_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [20:0] code_point;
      logic [2:0]  char_length;
      logic [2:0]  bytes_needed;
   } rsp_item_type;

endpackage

`default_nettype wire

[design/cesu8_sd_step.sv]
// ---------------------------------------------------------------------------
// CESU-8 decoder step
// Checks one byte against the automaton, merges its payload bits into the
// unit being built and forms the result item, if the byte gives one.
// ---------------------------------------------------------------------------
`default_nettype none

module cesu8_sd_step (
   input  wire cesu8_sd_pkg::dec_state_type cur_state,
   input  wire cesu8_sd_pkg::req_item_type  item,
   output cesu8_sd_pkg::dec_state_type      nxt_state,
   output cesu8_sd_pkg::rsp_item_type       result,
   output logic                             result_valid
);

   typedef enum logic [1:0] {
      STEP_MORE,
      STEP_ACCEPT,
      STEP_FAIL
   } step_kind_type;

   step_kind_type                     kind;
   cesu8_sd_pkg::automaton_state_type next_auto;
   logic [7:0]                        b;
   logic                              trail;
   logic [2:0]                        taken;
   logic [7:0]                        first_new;
   logic [15:0]                       unit_new;
   logic [2:0]                        total;

   assign b     = item.data_byte;
   assign trail = (b inside {[8'h80:8'hBF]});
   assign taken = 3'(cur_state.bytes_taken + 3'd1);

   // Automaton transition
   always_comb begin
      kind      = STEP_FAIL;
      next_auto = cesu8_sd_pkg::ST_START;
      case (cur_state.automaton_state)
         cesu8_sd_pkg::ST_START: begin
            if (b < 8'h80) begin
               kind = STEP_ACCEPT;
            end else if (b inside {[8'hC2:8'hDF]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LAST_TRAIL;
            end else if (b == 8'hE0) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_E0_SECOND;
            end else if (b == 8'hED) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_ED_SECOND;
            end else if (b inside {[8'hE1:8'hEF]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_MID_SECOND;
            end
         end
         cesu8_sd_pkg::ST_LAST_TRAIL: begin
            if (trail) kind = STEP_ACCEPT;
         end
         cesu8_sd_pkg::ST_E0_SECOND: begin
            if (b inside {[8'hA0:8'hBF]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LAST_TRAIL;
            end
         end
         cesu8_sd_pkg::ST_MID_SECOND: begin
            if (trail) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LAST_TRAIL;
            end
         end
         cesu8_sd_pkg::ST_ED_SECOND: begin
            if (b inside {[8'h80:8'h9F]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LAST_TRAIL;
            end else if (b inside {[8'hA0:8'hAF]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_HI_TRAIL;
            end
         end
         cesu8_sd_pkg::ST_HI_TRAIL: begin
            if (trail) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LOW_ED;
            end
         end
         cesu8_sd_pkg::ST_LOW_ED: begin
            if (b == 8'hED) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LOW_SECOND;
            end
         end
         cesu8_sd_pkg::ST_LOW_SECOND: begin
            if (b inside {[8'hB0:8'hBF]}) begin
               kind      = STEP_MORE;
               next_auto = cesu8_sd_pkg::ST_LAST_TRAIL;
            end
         end
         default: begin
            kind      = STEP_FAIL;
            next_auto = cesu8_sd_pkg::ST_START;
         end
      endcase
   end

   // Merge payload bits and advance the sequence state
   always_comb begin
      first_new = (cur_state.automaton_state == cesu8_sd_pkg::ST_START) ? b
                                                                       : cur_state.first_byte;
      if (cur_state.automaton_state == cesu8_sd_pkg::ST_START) begin
         unit_new = {8'h00, b & ((b >= 8'hE0) ? cesu8_sd_pkg::LEAD3_MASK
                                              : cesu8_sd_pkg::LEAD2_MASK)};
      end else if (cur_state.automaton_state == cesu8_sd_pkg::ST_LOW_ED) begin
         unit_new = {12'h000, b[3:0]};
      end else begin
         unit_new = {cur_state.unit_value[9:0], b[5:0]};
      end

      nxt_state            = cur_state;
      nxt_state.first_byte = first_new;
      nxt_state.unit_value = unit_new;
      if (kind == STEP_MORE && next_auto == cesu8_sd_pkg::ST_LOW_ED) begin
         nxt_state.high_surrogate_bits = unit_new[9:0];
      end
      // Restart on a finished, bad or cut-off sequence
      if (kind == STEP_MORE && !item.end_of_text) begin
         nxt_state.automaton_state = next_auto;
         nxt_state.bytes_taken     = taken;
      end else begin
         nxt_state.automaton_state = cesu8_sd_pkg::ST_START;
         nxt_state.bytes_taken     = 3'd0;
      end
   end

   // Form the result item
   always_comb begin
      total = (first_new >= 8'hE0) ? cesu8_sd_pkg::LEN_THREE : cesu8_sd_pkg::LEN_TWO;
      if (next_auto == cesu8_sd_pkg::ST_HI_TRAIL || next_auto == cesu8_sd_pkg::ST_LOW_ED ||
          next_auto == cesu8_sd_pkg::ST_LOW_SECOND ||
          (next_auto == cesu8_sd_pkg::ST_LAST_TRAIL && taken == cesu8_sd_pkg::TAKEN_FIVE)) begin
         total = cesu8_sd_pkg::LEN_PAIR;
      end

      result_valid        = (kind != STEP_MORE) || item.end_of_text;
      result.char_length  = taken;
      result.bytes_needed = 3'd0;
      result.code_point   = 21'd0;
      case (kind)
         STEP_ACCEPT: begin
            result.status = cesu8_sd_pkg::STATUS_CHAR;
            if (taken == cesu8_sd_pkg::TAKEN_ONE) begin
               result.code_point = {13'd0, b};
            end else if (taken == cesu8_sd_pkg::TAKEN_SIX) begin
               result.code_point = {1'b0, cur_state.high_surrogate_bits, unit_new[9:0]}
                                   + cesu8_sd_pkg::SURROGATE_BASE;
            end else begin
               result.code_point = {5'd0, unit_new};
            end
         end
         STEP_FAIL: begin
            result.status     = cesu8_sd_pkg::STATUS_INVALID;
            result.code_point = {13'd0, first_new};
         end
         default: begin
            result.status       = cesu8_sd_pkg::STATUS_TRUNCATED;
            result.bytes_needed = (total > taken) ? 3'(total - taken) : 3'd0;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/cesu8_stream_decoder_core.sv]
// ---------------------------------------------------------------------------
// CESU-8 stream decoder core
// Validating byte-serial decoder: one text byte per req item, at most one
// rsp item per byte.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one byte of CESU-8 text per item plus an end-of-text flag.
//   rsp channel: a status (character, invalid, truncated), the code point
//   or failing lead byte, the byte count and, when truncated, the bytes
//   still missing. Bytes inside a sequence give an rsp item only at end of text.
//   A taken byte waits in the input register; the step writes its rsp
//   item, if it gives one, into the rsp register.
//   Throughput: one byte per cycle while rsp is not stalled; the automaton step is one table
//   lookup and bit merge between the input register and the rsp register.
//   A stalled rsp stops the step; the input register still holds one more
//   byte, after which req_ready falls until the rsp item is taken.
//   Reset: the automaton returns to its start state, both registers empty.
//   A bad byte is dropped and decoding restarts at the next byte.
// ---------------------------------------------------------------------------
`default_nettype none
`include "cesu8_stream_decoder_core_macros.svh"

module cesu8_stream_decoder_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  cesu8_sd_pkg::req_item_type req_item,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output cesu8_sd_pkg::rsp_item_type       rsp_item
);

   logic                        in_valid_ff, in_valid_in;
   cesu8_sd_pkg::req_item_type  item_ff;
   cesu8_sd_pkg::dec_state_type state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cesu8_sd_pkg::rsp_item_type  rsp_item_ff;
   cesu8_sd_pkg::rsp_item_type  step_result;
   logic                        step_result_valid;
   logic                        advance;

   // Step the automaton when the rsp register is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   cesu8_sd_step u_step (
      .cur_state    (state_ff),
      .item         (item_ff),
      .nxt_state    (state_in),
      .result       (step_result),
      .result_valid (step_result_valid)
   );

   // Valid flags of both registers
   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      if (advance) begin
         rsp_valid_in = step_result_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers and automaton state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers: load the byte on accept, the result on a step
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) item_ff <= req_item;
      if (advance && step_result_valid) rsp_item_ff <= step_result;
   end

   `CSD_ASSERT_IMP(a_start_no_bytes, clock, reset,
      state_ff.automaton_state == cesu8_sd_pkg::ST_START,
      state_ff.bytes_taken == 3'd0, "start state with bytes pending")
   `CSD_ASSERT_IMP(a_trunc_needs, clock, reset,
      rsp_valid_ff && rsp_item_ff.status == cesu8_sd_pkg::STATUS_TRUNCATED,
      rsp_item_ff.bytes_needed != 3'd0 && rsp_item_ff.code_point == 21'd0,
      "truncated item malformed")
   `CSD_ASSERT_IMP(a_invalid_shape, clock, reset,
      rsp_valid_ff && rsp_item_ff.status == cesu8_sd_pkg::STATUS_INVALID,
      rsp_item_ff.bytes_needed == 3'd0 && rsp_item_ff.char_length != 3'd0,
      "invalid item malformed")
   `CSD_ASSERT_IMP(a_ascii_short, clock, reset,
      rsp_valid_ff && rsp_item_ff.status == cesu8_sd_pkg::STATUS_CHAR &&
      rsp_item_ff.char_length == 3'd1,
      rsp_item_ff.code_point < 21'h80, "one-byte character out of range")
   `CSD_ASSERT_NXT(a_input_held, clock, reset, in_valid_ff && !advance,
      in_valid_ff && $stable(item_ff), "held input byte lost")

endmodule

`default_nettype wire

[tb/sv/cesu8_stream_decoder_core_tb.sv]
// ---------------------------------------------------------------------------
// CESU-8 stream decoder testbench
// Drives byte-serial text into the decoder and checks every result item
// against an in-bench decoder model: a short opening of hand-picked
// sequences, then random text under several pacing patterns on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cesu8_stream_decoder_core_tb;

   // Decoder model plus the queue of result items still awaited from the block
   class cesu8_char_ledger;
      cesu8_sd_pkg::automaton_state_type dfa_state;
      logic [2:0]                        taken_count;
      logic [7:0]                        lead_byte;
      logic [15:0]                       unit_bits;
      logic [9:0]                        high_bits;
      cesu8_sd_pkg::rsp_item_type        awaited[$];
      int                                mismatches;
      int                                chars_seen;
      int                                invalid_seen;
      int                                truncated_seen;

      function new();
         dfa_state      = cesu8_sd_pkg::ST_START;
         taken_count    = 3'd0;
         lead_byte      = 8'h00;
         unit_bits      = 16'h0000;
         high_bits      = 10'h000;
         mismatches     = 0;
         chars_seen     = 0;
         invalid_seen   = 0;
         truncated_seen = 0;
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Step the automaton on one accepted byte; queue the result item it gives, if any
      function void note_byte(input cesu8_sd_pkg::req_item_type it);
         logic [7:0]                        b;
         logic [2:0]                        taken;
         logic [2:0]                        total;
         cesu8_sd_pkg::automaton_state_type nxt;
         logic                              done;
         logic                              bad;
         logic                              trail;
         cesu8_sd_pkg::rsp_item_type        r;
         b     = it.data_byte;
         taken = taken_count + 3'd1;
         trail = (b >= 8'h80 && b <= 8'hBF);
         done  = 1'b0;
         bad   = 1'b0;
         nxt   = cesu8_sd_pkg::ST_START;
         case (dfa_state)
            cesu8_sd_pkg::ST_START: begin
               if (b < 8'h80) done = 1'b1;
               else if (b >= 8'hC2 && b <= 8'hDF) nxt = cesu8_sd_pkg::ST_LAST_TRAIL;
               else if (b == 8'hE0) nxt = cesu8_sd_pkg::ST_E0_SECOND;
               else if (b == 8'hED) nxt = cesu8_sd_pkg::ST_ED_SECOND;
               else if (b >= 8'hE1 && b <= 8'hEF) nxt = cesu8_sd_pkg::ST_MID_SECOND;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_LAST_TRAIL: begin
               if (trail) done = 1'b1;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_E0_SECOND: begin
               if (b >= 8'hA0 && b <= 8'hBF) nxt = cesu8_sd_pkg::ST_LAST_TRAIL;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_MID_SECOND: begin
               if (trail) nxt = cesu8_sd_pkg::ST_LAST_TRAIL;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_ED_SECOND: begin
               if (b >= 8'h80 && b <= 8'h9F) nxt = cesu8_sd_pkg::ST_LAST_TRAIL;
               else if (b >= 8'hA0 && b <= 8'hAF) nxt = cesu8_sd_pkg::ST_HI_TRAIL;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_HI_TRAIL: begin
               if (trail) nxt = cesu8_sd_pkg::ST_LOW_ED;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_LOW_ED: begin
               if (b == 8'hED) nxt = cesu8_sd_pkg::ST_LOW_SECOND;
               else bad = 1'b1;
            end
            cesu8_sd_pkg::ST_LOW_SECOND: begin
               if (b >= 8'hB0 && b <= 8'hBF) nxt = cesu8_sd_pkg::ST_LAST_TRAIL;
               else bad = 1'b1;
            end
            default: bad = 1'b1;
         endcase

         // Merge the payload bits of this byte into the current unit
         if (dfa_state == cesu8_sd_pkg::ST_START) begin
            lead_byte = b;
            unit_bits = {8'h00, b & ((b >= 8'hE0) ? 8'h0F : 8'h1F)};
         end else if (dfa_state == cesu8_sd_pkg::ST_LOW_ED) begin
            unit_bits = {12'h000, b[3:0]};
         end else begin
            unit_bits = {unit_bits[9:0], b[5:0]};
         end
         if (!done && !bad && nxt == cesu8_sd_pkg::ST_LOW_ED) high_bits = unit_bits[9:0];

         r             = '0;
         r.char_length = taken;
         if (done) begin
            r.status = cesu8_sd_pkg::STATUS_CHAR;
            if (taken == 3'd1) r.code_point = {13'd0, b};
            else if (taken == 3'd6)
               r.code_point = {1'b0, high_bits, unit_bits[9:0]} + 21'h10000;
            else r.code_point = {5'd0, unit_bits};
         end else if (bad) begin
            r.status     = cesu8_sd_pkg::STATUS_INVALID;
            r.code_point = {13'd0, (dfa_state == cesu8_sd_pkg::ST_START) ? b : lead_byte};
         end else if (it.end_of_text) begin
            // Text ends inside a sequence: report what is still missing
            total = (lead_byte >= 8'hE0) ? 3'd3 : 3'd2;
            if (nxt == cesu8_sd_pkg::ST_HI_TRAIL || nxt == cesu8_sd_pkg::ST_LOW_ED ||
                nxt == cesu8_sd_pkg::ST_LOW_SECOND ||
                (nxt == cesu8_sd_pkg::ST_LAST_TRAIL && taken == 3'd5)) total = 3'd6;
            r.status       = cesu8_sd_pkg::STATUS_TRUNCATED;
            r.bytes_needed = (total > taken) ? total - taken : 3'd0;
         end else begin
            // Mid-sequence: advance and wait for more
            dfa_state   = nxt;
            taken_count = taken;
            return;
         end
         dfa_state   = cesu8_sd_pkg::ST_START;
         taken_count = 3'd0;
         awaited.push_back(r);
      endfunction

      // Compare one result item with the oldest awaited item
      task check_result(input cesu8_sd_pkg::rsp_item_type got);
         cesu8_sd_pkg::rsp_item_type want;
         case (got.status)
            cesu8_sd_pkg::STATUS_CHAR:      chars_seen++;
            cesu8_sd_pkg::STATUS_INVALID:   invalid_seen++;
            cesu8_sd_pkg::STATUS_TRUNCATED: truncated_seen++;
            default:                        ;
         endcase
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited: status %0d code point %h",
                                      got.status, got.code_point));
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.code_point !== want.code_point)
            report_mismatch($sformatf("code point %h, expected %h",
                                      got.code_point, want.code_point));
         if (got.char_length !== want.char_length)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      got.char_length, want.char_length));
         if (got.bytes_needed !== want.bytes_needed)
            report_mismatch($sformatf("bytes needed %0d, expected %0d",
                                      got.bytes_needed, want.bytes_needed));
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   cesu8_sd_pkg::req_item_type req_item;
   logic                       rsp_valid;
   logic                       rsp_ready;
   cesu8_sd_pkg::rsp_item_type rsp_item;

   int                         idle_pct;
   int                         stall_pct;
   int                         bytes_sent;
   cesu8_char_ledger           ledger;
   cesu8_sd_pkg::req_item_type text_q[$];
   cesu8_sd_pkg::req_item_type opening_text[25];

   cesu8_stream_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) ledger.note_byte(req_item);
      if (!reset && rsp_valid && rsp_ready) ledger.check_result(rsp_item);
   end

   // Stall the result channel at the current rate
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #5ms;
      $display("Run timed out with %0d results outstanding", ledger.awaited.size());
      $display("FAILURE");
      $finish;
   end

   function automatic logic [7:0] trail_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // Present one item, idling first at the current rate, and hold until taken
   task automatic send_byte(input cesu8_sd_pkg::req_item_type it);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_queued();
      while (text_q.size() != 0) send_byte(text_q.pop_front());
   endtask

   // Drop valid and wait for every awaited result, then let the pipe settle
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Queue one random token: mostly well-formed characters, some broken or noise
   task automatic add_token();
      logic [7:0]                 seq[$];
      int                         k;
      int                         cut;
      int                         eot_at;
      logic [7:0]                 b;
      cesu8_sd_pkg::req_item_type it;
      k = $urandom_range(0, 99);
      if (k < 20) begin
         seq.push_back(8'($urandom_range(0, 127)));
      end else if (k < 35) begin
         seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
         seq.push_back(trail_byte());
      end else if (k < 47) begin
         seq.push_back(8'hE0);
         seq.push_back(8'($urandom_range(8'hA0, 8'hBF)));
         seq.push_back(trail_byte());
      end else if (k < 57) begin
         b = 8'($urandom_range(8'hE1, 8'hEE));
         if (b == 8'hED) b = 8'hEF;
         seq.push_back(b);
         seq.push_back(trail_byte());
         seq.push_back(trail_byte());
      end else if (k < 65) begin
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'h80, 8'h9F)));
         seq.push_back(trail_byte());
      end else if (k < 88) begin
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hA0, 8'hAF)));
         seq.push_back(trail_byte());
         seq.push_back(8'hED);
         seq.push_back(8'($urandom_range(8'hB0, 8'hBF)));
         seq.push_back(trail_byte());
         // Break the pair part-way with an arbitrary byte
         if (k >= 80) begin
            cut = $urandom_range(1, 5);
            while (seq.size() > cut) void'(seq.pop_back());
            seq.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 3)) seq.push_back(8'($urandom_range(0, 255)));
      end
      eot_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, seq.size() - 1) : -1;
      foreach (seq[i]) begin
         it.data_byte   = seq[i];
         it.end_of_text = (i == eot_at);
         text_q.push_back(it);
      end
   endtask

   initial begin
      int phase_bytes;
      ledger     = new();
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      rsp_ready  = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      bytes_sent = 0;

      // Extremes of each sequence form, bad lead, bad trail, early end of text
      opening_text = '{
         {8'h00, 1'b0}, {8'h7F, 1'b1},
         {8'hC2, 1'b0}, {8'h80, 1'b0},
         {8'hDF, 1'b0}, {8'hBF, 1'b0},
         {8'hE0, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b0},
         {8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
         {8'hED, 1'b0}, {8'hAF, 1'b0}, {8'hBF, 1'b0},
         {8'hED, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
         {8'hFF, 1'b0},
         {8'hC2, 1'b0}, {8'h41, 1'b0},
         {8'hED, 1'b0}, {8'hA0, 1'b0}, {8'h80, 1'b0}, {8'hED, 1'b1}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_text[i]) text_q.push_back(opening_text[i]);
      send_queued();
      hold_until_drained();

      // Random text under four pacing patterns, draining between them
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         phase_bytes = 0;
         while (phase_bytes < 480) begin
            add_token();
            phase_bytes += text_q.size();
            send_queued();
         end
         hold_until_drained();
      end

      if (ledger.awaited.size() != 0)
         ledger.report_mismatch($sformatf("%0d results never arrived", ledger.awaited.size()));
      $display("Sent %0d text bytes: opening sequences, then random text over four pacings",
               bytes_sent);
      $display("Saw %0d characters, %0d invalid sequences, %0d truncated texts",
               ledger.chars_seen, ledger.invalid_seen, ledger.truncated_seen);
      if (ledger.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
